/* rtl/core/assert_macros.svh */
// Assertion macros shared by the address pattern fix RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define RAPF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RAPF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/rapf_pkg.sv */
// Package for the radio address pattern fix: widths, correction constants
// and the control struct passed from the sequencer to the shift datapath.
// No dependencies.
package rapf_pkg;

    localparam int ADDR_W     = 40;
    localparam int BYTE_W     = 8;
    localparam int OCT_N      = ADDR_W / BYTE_W;
    localparam int FIX_W      = 32;
    localparam int RUN_W      = 9;
    localparam int RUN_BIT    = 6;
    localparam int TOG_BIT    = 5;
    localparam int WIN_STEPS  = ADDR_W - BYTE_W;
    localparam int STEP_W     = $clog2(WIN_STEPS);
    localparam int PASS_COUNT = 3;
    localparam int PASS_W     = $clog2(PASS_COUNT);

    localparam logic [FIX_W-1:0]  OCT_FIX = 32'h8442_2110;
    localparam logic [BYTE_W-1:0] TOG_A   = 8'h55;
    localparam logic [BYTE_W-1:0] TOG_B   = 8'hAA;

    typedef struct packed {
        logic load;
        logic oct;
        logic step;
        logic fin;
    } rapf_ctrl_t;

endpackage

/* rtl/core/rapf_octet.sv */
// Equal-octet detector and correction mask generator.
// Depends on rapf_pkg.
module rapf_octet (
    input  logic [rapf_pkg::ADDR_W-1:0] addr,
    output logic [rapf_pkg::ADDR_W-1:0] mask,
    output logic                        hit
);
    import rapf_pkg::*;

    logic [BYTE_W-1:0] oct [OCT_N];
    logic [OCT_N-1:1]  diff0;
    logic              ref0_hit;
    logic              ref1_hit;

    always_comb begin
        for (int i = 0; i < OCT_N; i++) begin
            oct[i] = addr[i*BYTE_W +: BYTE_W];
        end
        for (int i = 1; i < OCT_N; i++) begin
            diff0[i] = (oct[i] != oct[0]);
        end
        ref0_hit = $onehot0(diff0);
        ref1_hit = (oct[2] == oct[1]) && (oct[3] == oct[1]) && (oct[4] == oct[1]);
        hit      = ref0_hit || ref1_hit;

        // skip over a differing octet 1 to 3; whole mask in the low 32 bits otherwise
        if (ref0_hit && diff0[1]) begin
            mask = {OCT_FIX[31:8], 8'h00, OCT_FIX[7:0]};
        end else if (ref0_hit && diff0[2]) begin
            mask = {OCT_FIX[31:16], 8'h00, OCT_FIX[15:0]};
        end else if (ref0_hit && diff0[3]) begin
            mask = {OCT_FIX[31:24], 8'h00, OCT_FIX[23:0]};
        end else begin
            mask = {{(ADDR_W-FIX_W){1'b0}}, OCT_FIX};
        end
    end

endmodule

/* rtl/core/rapf_serial.sv */
// Address shift register with the bit-serial window check.
// Depends on rapf_pkg and rapf_octet.
module rapf_serial (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rapf_pkg::rapf_ctrl_t        ctrl,
    input  logic [rapf_pkg::ADDR_W-1:0] load_addr,
    output logic [rapf_pkg::ADDR_W-1:0] addr,
    output logic                        hit
);
    import rapf_pkg::*;

    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [ADDR_W-1:0] oct_mask;
    logic              oct_hit;
    logic [ADDR_W-1:0] tmp;
    logic [RUN_W-1:0]  win;
    logic [BYTE_W-1:0] lo_byte;

    rapf_octet u_octet (
        .addr (addr_reg),
        .mask (oct_mask),
        .hit  (oct_hit)
    );

    always_comb begin
        tmp       = addr_reg;
        win       = addr_reg[RUN_W-1:0];
        lo_byte   = addr_reg[BYTE_W-1:0];
        addr_next = addr_reg;
        hit       = 1'b0;
        if (ctrl.load) begin
            addr_next = load_addr;
        end else if (ctrl.oct) begin
            hit = oct_hit;
            if (oct_hit) begin
                addr_next = addr_reg ^ oct_mask;
            end
        end else if (ctrl.step) begin
            if (win == '0 || (&win)) begin
                tmp[RUN_BIT] = ~tmp[RUN_BIT];
                hit          = 1'b1;
            end else if (lo_byte == TOG_A || lo_byte == TOG_B) begin
                tmp[TOG_BIT] = ~tmp[TOG_BIT];
                hit          = 1'b1;
            end
            addr_next = {tmp[0], tmp[ADDR_W-1:1]};
        end else if (ctrl.fin) begin
            if (lo_byte == TOG_A || lo_byte == TOG_B) begin
                tmp[TOG_BIT] = ~tmp[TOG_BIT];
                hit          = 1'b1;
            end
            // back into place after the window sweep
            addr_next = {tmp[BYTE_W-1:0], tmp[ADDR_W-1:BYTE_W]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0;
        end else begin
            addr_reg <= addr_next;
        end
    end

    assign addr = addr_reg;

endmodule

/* rtl/core/radio_address_pattern_fix.sv */
// Radio base address pattern fix, 40-bit. One corrected address per item
// taken on the s_ channel, delivered on the m_ channel. An item takes one
// to three passes from acceptance to a result: each pass runs equal-octet
// correction, the window sweep, a check of the top byte and a decision,
// all on a single 40-bit shift register rotated one bit per sweep step.
// The last decision cycle waits while the output register still holds an
// unaccepted result. A new item is taken from the cycle after the previous
// result has moved to the output register. Depends on rapf_pkg,
// rapf_serial, rapf_octet, assert_macros.svh.
`include "assert_macros.svh"

module radio_address_pattern_fix (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rapf_pkg::ADDR_W-1:0] s_address_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rapf_pkg::ADDR_W-1:0] m_address_out
);
    import rapf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_OCT  = 3'd1;
    localparam logic [2:0] ST_WIN  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(WIN_STEPS - 1);
    localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(PASS_COUNT - 1);

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic              fix_reg, fix_next;
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] m_addr_reg, m_addr_next;
    rapf_ctrl_t        ctrl;
    logic [ADDR_W-1:0] cur_addr;
    logic              hit;

    rapf_serial u_serial (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .load_addr (s_address_in),
        .addr      (cur_addr),
        .hit       (hit)
    );

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        pass_next    = pass_reg;
        fix_next     = fix_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_addr_next  = m_addr_reg;
        ctrl         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctrl.load  = 1'b1;
                    pass_next  = '0;
                    state_next = ST_OCT;
                end
            end
            ST_OCT: begin
                ctrl.oct   = 1'b1;
                fix_next   = hit;
                step_next  = '0;
                state_next = ST_WIN;
            end
            ST_WIN: begin
                ctrl.step = 1'b1;
                fix_next  = fix_reg || hit;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                ctrl.fin   = 1'b1;
                fix_next   = fix_reg || hit;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (fix_reg && pass_reg != PASS_LAST) begin
                    pass_next  = pass_reg + 1'b1;
                    state_next = ST_OCT;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_addr_next  = cur_addr;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            pass_reg    <= '0;
            fix_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            pass_reg    <= pass_next;
            fix_reg     <= fix_next;
            m_valid_reg <= m_valid_next;
        end
        m_addr_reg <= m_addr_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_address_out = m_addr_reg;

    `RAPF_ASSERT_ALWAYS(a_reset_idle, aclk,
        !aresetn |=> (state_reg == ST_IDLE && !m_valid_reg), "reset must leave block idle")
    `RAPF_ASSERT(a_busy_after_accept, aclk, aresetn,
        (s_valid && s_ready) |=> (state_reg == ST_OCT && !s_ready), "item not started")
    `RAPF_ASSERT(a_sweep_end, aclk, aresetn,
        (state_reg == ST_WIN && step_reg == STEP_LAST) |=> (state_reg == ST_FIN),
        "window sweep overran")
    `RAPF_ASSERT(a_pass_limit, aclk, aresetn,
        (state_reg == ST_DONE && pass_reg == PASS_LAST) |=> (state_reg != ST_OCT),
        "too many passes")

endmodule

/* test/tb.sv */
// Testbench for radio_address_pattern_fix: drives raw 40-bit addresses and
// checks each corrected address against a local model of the three-pass fix.
// Depends on rapf_pkg and the radio_address_pattern_fix RTL.
module tb;
    import rapf_pkg::*;

    typedef struct {
        logic [ADDR_W-1:0] raw;
        logic [ADDR_W-1:0] fixed;
    } addr_pair_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [ADDR_W-1:0] s_address_in = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [ADDR_W-1:0] m_address_out;

    logic [ADDR_W-1:0] raw_addrs[$];
    addr_pair_t        fixed_addrs[$];
    int                sent_cnt = 0;
    int                err_cnt = 0;
    int                src_wait = 0;
    int                sink_wait = 0;
    bit                src_calm = 1'b0;
    bit                sink_calm = 1'b0;

    radio_address_pattern_fix dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_address_in (s_address_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_address_out(m_address_out)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [ADDR_W-1:0] corrected_address(logic [ADDR_W-1:0] raw);
        logic [63:0] a;
        logic [63:0] low;
        logic [63:0] fix;
        logic [7:0]  octs [OCT_N];
        int          cnt;
        int          pos;
        int          fixes;
        bit          hit;
        bit          settled;
        a = 64'(raw);
        fix = 64'(OCT_FIX);
        settled = 1'b0;
        for (int pass = 0; pass < PASS_COUNT && !settled; pass++) begin
            fixes = 0;
            hit = 1'b0;
            for (int k = 0; k < OCT_N; k++)
                octs[k] = a[k*BYTE_W +: BYTE_W];
            for (int rsel = 0; rsel < 2 && !hit; rsel++) begin
                cnt = rsel;
                pos = OCT_N;
                for (int k = rsel + 1; k < OCT_N; k++) begin
                    if (octs[k] != octs[rsel]) begin
                        cnt++;
                        pos = k;
                    end
                end
                if (cnt <= 1) begin
                    low = (64'd1 << (pos * BYTE_W)) - 64'd1;
                    a = a ^ (((fix & ~low) << BYTE_W) | (fix & low));
                    fixes++;
                    hit = 1'b1;
                end
            end
            for (int i = 0; i <= ADDR_W - RUN_W; i++) begin
                if (a[i +: RUN_W] == '0 || a[i +: RUN_W] == '1) begin
                    a[i + RUN_BIT] = ~a[i + RUN_BIT];
                    fixes++;
                end else if (a[i +: BYTE_W] == TOG_A || a[i +: BYTE_W] == TOG_B) begin
                    a[i + TOG_BIT] = ~a[i + TOG_BIT];
                    fixes++;
                end
            end
            if (a[WIN_STEPS +: BYTE_W] == TOG_A || a[WIN_STEPS +: BYTE_W] == TOG_B) begin
                a[WIN_STEPS + TOG_BIT] = ~a[WIN_STEPS + TOG_BIT];
                fixes++;
            end
            if (fixes == 0)
                settled = 1'b1;
        end
        return a[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    // calm stretches give runs of back-to-back items
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 15) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic logic [ADDR_W-1:0] octet_pattern(int skip, logic [7:0] b, logic [7:0] d);
        logic [ADDR_W-1:0] a;
        for (int k = 0; k < OCT_N; k++)
            a[k*BYTE_W +: BYTE_W] = (k == skip) ? d : b;
        return a;
    endfunction

    // source side
    always @(posedge aclk) begin
        int w;
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_wait <= 0;
        end else begin
            if (s_valid && s_ready) begin
                fixed_addrs.push_back('{s_address_in, corrected_address(s_address_in)});
                sent_cnt <= sent_cnt + 1;
            end
            if (!s_valid || s_ready) begin
                if (src_wait > 0) begin
                    s_valid <= 1'b0;
                    src_wait <= src_wait - 1;
                end else if (raw_addrs.size() != 0) begin
                    s_valid <= 1'b1;
                    s_address_in <= raw_addrs.pop_front();
                    w = draw_wait(src_calm);
                    src_wait <= w;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        addr_pair_t exp_pair;
        int         w;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_wait <= 0;
        end else if (m_valid && m_ready) begin
            if (fixed_addrs.size() == 0) begin
                if (err_cnt < 10)
                    $display("unexpected result %h", m_address_out);
                err_cnt <= err_cnt + 1;
            end else begin
                exp_pair = fixed_addrs.pop_front();
                if (m_address_out !== exp_pair.fixed) begin
                    if (err_cnt < 10)
                        $display("mismatch: in %h expected %h got %h",
                                 exp_pair.raw, exp_pair.fixed, m_address_out);
                    err_cnt <= err_cnt + 1;
                end
            end
            w = draw_wait(sink_calm);
            sink_wait <= w;
            m_ready <= (w == 0);
        end else if (sink_wait > 0) begin
            sink_wait <= sink_wait - 1;
            m_ready <= (sink_wait == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        logic [ADDR_W-1:0] a;
        logic [63:0]       a64;
        int                total;
        int                kind;
        int                p;
        aresetn = 1'b0;

        raw_addrs.push_back(40'h00_0000_0000);
        raw_addrs.push_back(40'hFF_FFFF_FFFF);
        raw_addrs.push_back(40'h55_5555_5555);
        raw_addrs.push_back(40'hAA_AAAA_AAAA);
        raw_addrs.push_back(40'h3C_3C3C_3C3C);
        for (int k = 0; k < OCT_N; k++)
            raw_addrs.push_back(octet_pattern(k, 8'h12, 8'hE7));
        raw_addrs.push_back(40'h12_1212_3456);
        raw_addrs.push_back(40'h00_0000_01FF);
        raw_addrs.push_back(40'h00_00FF_FF00);
        raw_addrs.push_back(40'hFF_FE00_7FFF);
        raw_addrs.push_back(40'h55_1234_5678);
        raw_addrs.push_back(40'hAA_8765_4321);
        raw_addrs.push_back(40'h80_0000_0001);
        raw_addrs.push_back(40'h7F_FFFF_FFFE);
        raw_addrs.push_back(40'hC3_A5C3_5AC3);
        raw_addrs.push_back(40'h96_D3B1_E24C);

        for (int n = 0; n < 1050; n++) begin
            kind = $urandom_range(0, 9);
            a = rand_addr();
            if (kind <= 2) begin
                a = octet_pattern($urandom_range(0, OCT_N), a[7:0], a[15:8]);
            end else if (kind <= 4) begin
                a64 = 64'(a);
                p = $urandom_range(0, WIN_STEPS);
                a64[p +: BYTE_W] = $urandom_range(0, 1) ? TOG_A : TOG_B;
                a = a64[ADDR_W-1:0];
            end else if (kind == 5) begin
                a64 = 64'(a);
                p = $urandom_range(0, ADDR_W - RUN_W);
                a64[p +: RUN_W] = $urandom_range(0, 1) ? '1 : '0;
                a = a64[ADDR_W-1:0];
            end
            raw_addrs.push_back(a);
        end
        total = raw_addrs.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        while (sent_cnt < total) @(posedge aclk);
        while (fixed_addrs.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (err_cnt == 0 && fixed_addrs.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #6000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/rapf_pkg.sv
rtl/core/rapf_octet.sv
rtl/core/rapf_serial.sv
rtl/core/radio_address_pattern_fix.sv
test/tb.sv
